/* hdl/stq_pkg.sv */
// Shared types and codes for the sorted timer queue.
// Used by stq_front, stq_back and sorted_timer_queue; no dependencies.
package stq_pkg;

   localparam int SLOTS_DEFAULT = 32;

   // Request modes.
   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_ELAPSE = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Result kinds.
   localparam logic [2:0] KIND_CREATED   = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_CANCELLED = 3'd2;
   localparam logic [2:0] KIND_NO_MATCH  = 3'd3;
   localparam logic [2:0] KIND_DELIVERED = 3'd4;
   localparam logic [2:0] KIND_DROPPED   = 3'd5;
   localparam logic [2:0] KIND_DONE      = 3'd6;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] time_ms;
      logic [31:0] handler_tag;
      logic [31:0] data_a;
      logic [31:0] data_b;
      logic [31:0] mailbox;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] handler_tag_res;
      logic [31:0] data_a_res;
      logic [31:0] data_b_res;
      logic [31:0] mailbox_res;
      logic        last;
   } rsp_type;

   // One timer entry as held in the sorted list.
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] handler;
      logic [31:0] data_a;
      logic [31:0] data_b;
      logic [31:0] mailbox;
   } entry_type;

endpackage

/* hdl/stq_front.sv */
// Front end: accepts request words, drops the unused mode and queues the rest.
// Depends on stq_pkg.
module stq_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  stq_pkg::req_type req_data,
   output logic            q_valid,
   output stq_pkg::req_type q_data,
   input  logic            q_pop
);
   import stq_pkg::*;

   req_type    buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   // A word with the unused mode is accepted and discarded.
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_data.mode != MODE_UNUSED);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = buf_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

/* hdl/stq_back.sv */
// Back end: sorted timer list in a row of entry registers and the sequencer
// that walks it for create, cancel and elapse. Depends on stq_pkg.
module stq_back #(
   parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  stq_pkg::req_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);
   localparam int IW = $clog2(SLOTS);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CREATE = 3'd1;
   localparam logic [2:0] S_CANCEL = 3'd2;
   localparam logic [2:0] S_EXPIRE = 3'd3;
   localparam logic [2:0] S_SUB    = 3'd4;

   logic [2:0]    state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   entry_type     ent_ff [SLOTS];
   entry_type     ent_in [SLOTS];
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          emit;
   rsp_type       emit_data;
   entry_type     cur;
   entry_type     new_ent;
   logic          do_insert;
   logic          do_remove;
   logic          do_sub;
   logic [CW-1:0] op_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur       = ent_ff[pos_ff[IW-1:0]];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      new_ent.rem     = cmd_ff.time_ms;
      new_ent.handler = cmd_ff.handler_tag;
      new_ent.data_a  = cmd_ff.data_a;
      new_ent.data_b  = cmd_ff.data_b;
      new_ent.mailbox = cmd_ff.mailbox;
   end

   // Sequencer: one list position per cycle, one result word per cycle while the result channel is not stalled.
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_data = '0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_sub    = 1'b0;
      op_pos    = pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               pos_in = '0;
               priority case (q_data.mode)
                  MODE_CREATE: state_in = S_CREATE;
                  MODE_CANCEL: state_in = S_CANCEL;
                  default:     state_in = S_EXPIRE;
               endcase
            end
         end
         S_CREATE: begin
            if (count_ff == FULL_COUNT) begin
               if (out_free) begin
                  emit           = 1'b1;
                  emit_data.kind = KIND_FULL;
                  emit_data.last = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (pos_ff < count_ff && cur.rem <= cmd_ff.time_ms) begin
               pos_in = pos_ff + 1'b1;
            end else if (out_free) begin
               do_insert      = 1'b1;
               count_in       = count_ff + 1'b1;
               emit           = 1'b1;
               emit_data.kind = KIND_CREATED;
               emit_data.last = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CANCEL: begin
            if (pos_ff == count_ff) begin
               if (out_free) begin
                  emit           = 1'b1;
                  emit_data.kind = KIND_NO_MATCH;
                  emit_data.last = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (cur.handler == cmd_ff.handler_tag && cur.data_a == cmd_ff.data_a
                         && cur.data_b == cmd_ff.data_b) begin
               if (out_free) begin
                  do_remove      = 1'b1;
                  count_in       = count_ff - 1'b1;
                  emit           = 1'b1;
                  emit_data.kind = KIND_CANCELLED;
                  emit_data.last = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_EXPIRE: begin
            // The head entry is at position zero; pos_ff stays zero here.
            op_pos = '0;
            if (cmd_ff.time_ms != 32'd0 && count_ff != '0 && ent_ff[0].rem <= cmd_ff.time_ms)
            begin
               if (out_free) begin
                  do_remove                 = 1'b1;
                  count_in                  = count_ff - 1'b1;
                  emit                      = 1'b1;
                  emit_data.kind            = (ent_ff[0].handler == 32'd0
                                               || ent_ff[0].mailbox == 32'd0)
                                              ? KIND_DROPPED : KIND_DELIVERED;
                  emit_data.handler_tag_res = ent_ff[0].handler;
                  emit_data.data_a_res      = ent_ff[0].data_a;
                  emit_data.data_b_res      = ent_ff[0].data_b;
                  emit_data.mailbox_res     = ent_ff[0].mailbox;
               end
            end else begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            if (out_free) begin
               do_sub         = 1'b1;
               emit           = 1'b1;
               emit_data.kind = KIND_DONE;
               emit_data.last = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Each list cell looks only at its neighbors to shift on insert or remove; on elapse it subtracts the time.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ent_in[i] = ent_ff[i];
         if (do_insert) begin
            if (CW'(i) == op_pos) begin
               ent_in[i] = new_ent;
            end else if (i > 0 && CW'(i) > op_pos && CW'(i) <= count_ff) begin
               ent_in[i] = ent_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove) begin
            if (i < SLOTS - 1 && CW'(i) >= op_pos && CW'(i + 1) < count_ff) begin
               ent_in[i] = ent_ff[(i < SLOTS - 1) ? i + 1 : i];
            end
         end else if (do_sub) begin
            if (CW'(i) < count_ff) begin
               ent_in[i].rem = ent_ff[i].rem - cmd_ff.time_ms;
            end
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and list cells.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < SLOTS; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

endmodule

/* hdl/sorted_timer_queue.sv */
// Top level of the sorted timer queue: request queue front end and list back end.
// Depends on stq_pkg, stq_front and stq_back.
//
//   channel   ports                          direction   word
//   request   req_valid req_stall req_data    in          stq_pkg::req_type
//   result    rsp_valid rsp_stall rsp_data    out         stq_pkg::rsp_type
//
// Create and cancel walk the list with the one-entry-per-cycle scan up to the
// list position where they insert or match (at most SLOTS). Elapse emits one
// result word per expired entry, then a done word. Reset is synchronous and
// clears the list to empty at once. A stalled result holds any step that emits
// a word; two request words queue in front while the back end is busy.
module sorted_timer_queue #(
   parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   logic    q_valid;
   req_type q_data;
   logic    q_pop;

   stq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   stq_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/sorted_timer_queue_checker.sv */
// Checker for the sorted timer queue: watches both channels, predicts results.
// Depends on stq_pkg; instantiated by sorted_timer_queue_tb.
`timescale 1ns / 100ps

module sorted_timer_queue_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  stq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  stq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import stq_pkg::*;

   localparam int NSLOT = 32;

   // Predicted timer list, kept in list order.
   entry_type timer_list[$];
   rsp_type   pending_rsp[$];

   assign pending_count = pending_rsp.size();

   function automatic rsp_type make_rsp(logic [2:0] k, entry_type e, logic has, logic lst);
      rsp_type r;
      r.kind = k;
      r.handler_tag_res = has ? e.handler : '0;
      r.data_a_res = has ? e.data_a : '0;
      r.data_b_res = has ? e.data_b : '0;
      r.mailbox_res = has ? e.mailbox : '0;
      r.last = lst;
      return r;
   endfunction

   // Apply one request word to the predicted list and queue its results.
   task automatic predict_timers(req_type q);
      entry_type e;
      entry_type none;
      int pos;
      bit hit;
      none = '0;
      e.rem = q.time_ms;
      e.handler = q.handler_tag;
      e.data_a = q.data_a;
      e.data_b = q.data_b;
      e.mailbox = q.mailbox;
      case (q.mode)
         MODE_CREATE: begin
            if (timer_list.size() >= NSLOT) begin
               pending_rsp.push_back(make_rsp(KIND_FULL, none, 0, 1));
            end else begin
               // Ties keep arrival order: go after every equal entry.
               pos = 0;
               while (pos < timer_list.size() && timer_list[pos].rem <= q.time_ms) pos++;
               timer_list.insert(pos, e);
               pending_rsp.push_back(make_rsp(KIND_CREATED, none, 0, 1));
            end
         end
         MODE_CANCEL: begin
            hit = 0;
            // Only the first matching entry in list order is removed.
            for (int i = 0; i < timer_list.size(); i++) begin
               if (timer_list[i].handler == q.handler_tag &&
                   timer_list[i].data_a == q.data_a && timer_list[i].data_b == q.data_b) begin
                  timer_list.delete(i);
                  hit = 1;
                  break;
               end
            end
            pending_rsp.push_back(make_rsp(hit ? KIND_CANCELLED : KIND_NO_MATCH, none, 0, 1));
         end
         MODE_ELAPSE: begin
            if (q.time_ms != 0) begin
               while (timer_list.size() > 0 && timer_list[0].rem <= q.time_ms) begin
                  e = timer_list.pop_front();
                  pending_rsp.push_back(make_rsp(
                     (e.handler == 0 || e.mailbox == 0) ? KIND_DROPPED : KIND_DELIVERED,
                     e, 1, 0));
               end
               foreach (timer_list[i]) timer_list[i].rem -= q.time_ms;
            end
            pending_rsp.push_back(make_rsp(KIND_DONE, none, 0, 1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timer_list.delete();
         pending_rsp.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) predict_timers(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (want.kind !== rsp_data.kind ||
                   want.handler_tag_res !== rsp_data.handler_tag_res ||
                   want.data_a_res !== rsp_data.data_a_res ||
                   want.data_b_res !== rsp_data.data_b_res ||
                   want.mailbox_res !== rsp_data.mailbox_res ||
                   want.last !== rsp_data.last) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %h got %h", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* tb/sv/sorted_timer_queue_tb.sv */
// Testbench top for the sorted timer queue: clock, reset, stimulus and verdict.
// Depends on stq_pkg, sorted_timer_queue and sorted_timer_queue_checker.
`timescale 1ns / 100ps

module sorted_timer_queue_tb;
   import stq_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      quiet = 0;

   // Handler tags and data words come from a small pool so cancels can hit.
   logic [31:0] tag_pool[4] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h5A5A_A5A5};

   sorted_timer_queue i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sorted_timer_queue_checker i_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // Receiver stalls in random bursts.
   always @(negedge clock) begin
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 3);
         rsp_stall <= 1;
         repeat (n) @(negedge clock);
      end
      rsp_stall <= 0;
   end

   // Drive one request word and wait for it to be taken. Valid stays high
   // into the next word unless an idle gap follows.
   task automatic send_word(logic [1:0] m, logic [31:0] t, logic [31:0] h,
                            logic [31:0] a, logic [31:0] b, logic [31:0] mb);
      req_data <= '{mode: m, time_ms: t, handler_tag: h, data_a: a, data_b: b, mailbox: mb};
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_word();
      return ($urandom_range(0, 3) == 0) ? $urandom() : tag_pool[$urandom_range(0, 3)];
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      int r;
      logic [1:0] m;
      logic [31:0] t;
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: extremes, ties, zero tags, cancel misses, full pool, unused mode.
      send_word(MODE_ELAPSE, 0, 0, 0, 0, 0);
      send_word(MODE_CANCEL, 0, 0, 0, 0, 0);
      send_word(MODE_CREATE, 32'hFFFF_FFFF, '1, '1, '1, '1);
      send_word(MODE_CREATE, 5, 0, 1, 2, 3);
      send_word(MODE_CREATE, 5, 7, 1, 2, 0);
      send_word(MODE_CREATE, 5, 7, 8, 9, 10);
      send_word(MODE_CREATE, 0, 0, 0, 0, 0);
      send_word(MODE_UNUSED, 1, 1, 1, 1, 1);
      send_word(MODE_CANCEL, 0, 0, 0, 0, 0);
      send_word(MODE_CANCEL, 3, 3, 3, 3, 3);
      send_word(MODE_ELAPSE, 0, 0, 0, 0, 0);
      send_word(MODE_ELAPSE, 5, 0, 0, 0, 0);
      send_word(MODE_ELAPSE, 32'hFFFF_FFFF, 0, 0, 0, 0);
      for (int i = 0; i < 34; i++) send_word(MODE_CREATE, $urandom_range(0, 50), i, 0, 0, 1);
      wait_drained();
      send_word(MODE_ELAPSE, 32'hFFFF_FFFF, 0, 0, 0, 0);

      // Random: mostly creates and elapses of small times, some cancels.
      for (int i = 0; i < 360; i++) begin
         if (i == 300) begin
            wait_drained();
            quiet = 1;
         end
         r = $urandom_range(0, 99);
         m = (r < 50) ? MODE_CREATE : (r < 70) ? MODE_CANCEL : (r < 97) ? MODE_ELAPSE
             : MODE_UNUSED;
         t = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60);
         send_word(m, t, pick_word(), pick_word(), pick_word(), pick_word());
      end
      send_word(MODE_ELAPSE, 32'hFFFF_FFFF, 0, 0, 0, 0);
      wait_drained();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end
endmodule

/* sorted_timer_queue.f */
hdl/stq_pkg.sv
hdl/stq_front.sv
hdl/stq_back.sv
hdl/sorted_timer_queue.sv
tb/sv/sorted_timer_queue_checker.sv
tb/sv/sorted_timer_queue_tb.sv
